[sv/assert_macros.svh]
// Assertion macros used by the checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/slfb_pkg.sv]
// Package for the status LED fade/blink block: types, codes and reset values.
// No dependencies.
package slfb_pkg;

  localparam int unsigned TimerWidthDef = 16;

  localparam logic [7:0]  MaxBrightRst = 8'd64;
  localparam logic [15:0] FadeIvlRst   = 16'd80;
  localparam logic [15:0] BlinkIvlRst  = 16'd500;
  localparam logic [7:0]  HoldStepsRst = 8'd25;
  localparam logic [7:0]  DutyTop      = 8'd255;

  typedef enum logic [2:0] {
    MODE_OFF         = 3'd0,
    MODE_BLUE_ON     = 3'd1,
    MODE_WHITE_ON    = 3'd2,
    MODE_BLUE_FADE   = 3'd3,
    MODE_WHITE_FADE  = 3'd4,
    MODE_BLUE_BLINK  = 3'd5,
    MODE_WHITE_BLINK = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    CFG_MODE       = 3'd0,
    CFG_MAX_BRIGHT = 3'd1,
    CFG_FADE_IVL   = 3'd2,
    CFG_BLINK_IVL  = 3'd3,
    CFG_HOLD_STEPS = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  max_bright;
    logic [15:0] fade_ivl;
    logic [15:0] blink_ivl;
    logic [7:0]  hold_steps;
  } cfg_t;

  typedef struct packed {
    logic [7:0] duty;
    dir_e       dir;
    logic [7:0] hold;
  } fade_state_t;

  typedef struct packed {
    logic [7:0] blue_duty;
    logic [7:0] white_duty;
    logic       stepped;
    logic [2:0] current_mode;
  } result_t;

endpackage

[sv/slfb_step.sv]
// Per-tick update: interval timer, fade/blink duty step and channel mapping.
// Depends on slfb_pkg.
module slfb_step #(
  parameter int unsigned TIMER_WIDTH = slfb_pkg::TimerWidthDef
) (
  input  slfb_pkg::cfg_t        cfg_i,
  input  slfb_pkg::fade_state_t state_i,
  input  logic [TIMER_WIDTH-1:0] elapsed_i,
  input  logic                  tick_i,
  output slfb_pkg::fade_state_t state_o,
  output logic [TIMER_WIDTH-1:0] elapsed_o,
  output slfb_pkg::result_t     result_o
);

  localparam int unsigned CmpW = (TIMER_WIDTH + 1 > 17) ? TIMER_WIDTH + 1 : 17;

  logic                  is_fade;
  logic                  is_blink;
  logic [15:0]           interval;
  logic [CmpW-1:0]       next_cnt;
  logic [CmpW-1:0]       ivl_ext;
  logic                  fire;
  logic                  step_hit;
  logic [7:0]            moved;
  slfb_pkg::fade_state_t faded;

  assign is_fade  = (cfg_i.mode == slfb_pkg::MODE_BLUE_FADE) ||
                    (cfg_i.mode == slfb_pkg::MODE_WHITE_FADE);
  assign is_blink = (cfg_i.mode == slfb_pkg::MODE_BLUE_BLINK) ||
                    (cfg_i.mode == slfb_pkg::MODE_WHITE_BLINK);
  assign interval = is_blink ? cfg_i.blink_ivl : cfg_i.fade_ivl;
  assign next_cnt = {{(CmpW-TIMER_WIDTH){1'b0}}, elapsed_i} + CmpW'(1);
  assign ivl_ext  = {{(CmpW-16){1'b0}}, interval};
  assign fire     = tick_i && (next_cnt > ivl_ext);

  always_comb begin
    case (state_i.dir)
      slfb_pkg::DIR_UP: begin
        moved = (state_i.duty != slfb_pkg::DutyTop) ? state_i.duty + 8'd1 : state_i.duty;
      end
      slfb_pkg::DIR_DOWN: begin
        moved = (state_i.duty != 8'd0) ? state_i.duty - 8'd1 : state_i.duty;
      end
      default: begin
        moved = state_i.duty;
      end
    endcase
    faded.duty = moved;
    faded.dir  = state_i.dir;
    faded.hold = state_i.hold;
    if (moved == 8'd0 && state_i.hold != 8'd0) begin
      faded.dir  = slfb_pkg::DIR_HOLD;
      faded.hold = state_i.hold - 8'd1;
    end else if (moved == 8'd0) begin
      faded.dir = slfb_pkg::DIR_UP;
    end else if (moved >= cfg_i.max_bright) begin
      faded.dir  = slfb_pkg::DIR_DOWN;
      faded.hold = cfg_i.hold_steps;
    end
  end

  always_comb begin
    state_o   = state_i;
    elapsed_o = elapsed_i;
    step_hit  = 1'b0;
    if (tick_i) begin
      if (fire) begin
        elapsed_o = '0;
        if (is_fade) begin
          state_o  = faded;
          step_hit = 1'b1;
        end else if (is_blink) begin
          state_o.duty = (state_i.duty == 8'd0) ? cfg_i.max_bright : 8'd0;
          step_hit     = 1'b1;
        end
      end else begin
        elapsed_o = next_cnt[TIMER_WIDTH] ? '1 : next_cnt[TIMER_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    result_o.blue_duty    = 8'd0;
    result_o.white_duty   = 8'd0;
    result_o.stepped      = step_hit;
    result_o.current_mode = cfg_i.mode;
    case (cfg_i.mode)
      slfb_pkg::MODE_BLUE_ON:     result_o.blue_duty  = cfg_i.max_bright;
      slfb_pkg::MODE_WHITE_ON:    result_o.white_duty = cfg_i.max_bright;
      slfb_pkg::MODE_BLUE_FADE,
      slfb_pkg::MODE_BLUE_BLINK:  result_o.blue_duty  = state_o.duty;
      slfb_pkg::MODE_WHITE_FADE,
      slfb_pkg::MODE_WHITE_BLINK: result_o.white_duty = state_o.duty;
      default: begin
      end
    endcase
  end

endmodule

[sv/status_led_fade_blink.sv]
// Top level of the two-channel status LED duty generator.
// Depends on slfb_pkg and slfb_step.
//
// Each request carries one millisecond tick; the block accepts one request per clock and
// returns its result from an output register the cycle after acceptance. The input stays
// ready whenever the output register is empty or is being drained in the same cycle, so
// the sustained rate is one request per cycle, set by the single timer/duty update stage.
// Configuration writes are taken at any time (cfg_ready_o is always high) and must only
// be issued while no request is in flight. A mode write clears the duty and hold count.
module status_led_fade_blink #(
  parameter int unsigned TIMER_WIDTH = slfb_pkg::TimerWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        tick_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  blue_duty_o,
  output logic [7:0]  white_duty_o,
  output logic        stepped_o,
  output logic [2:0]  current_mode_o
);

  slfb_pkg::cfg_t        cfg_q, cfg_d;
  slfb_pkg::fade_state_t state_q, state_d, step_state;
  logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d, step_elapsed;
  slfb_pkg::result_t     result_q, step_result;
  logic                  out_valid_q, out_valid_d;
  logic                  in_acc;
  logic                  cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  slfb_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .elapsed_i (elapsed_q),
    .tick_i    (tick_i),
    .state_o   (step_state),
    .elapsed_o (step_elapsed),
    .result_o  (step_result)
  );

  always_comb begin
    cfg_d     = cfg_q;
    state_d   = state_q;
    elapsed_d = elapsed_q;
    if (in_acc) begin
      state_d   = step_state;
      elapsed_d = step_elapsed;
    end
    if (cfg_acc) begin
      case (slfb_pkg::cfg_idx_e'(cfg_index_i))
        slfb_pkg::CFG_MODE: begin
          cfg_d.mode = slfb_pkg::mode_e'(cfg_data_i[2:0]);
          state_d.duty = 8'd0;
          state_d.dir  = slfb_pkg::DIR_UP;
          state_d.hold = 8'd0;
        end
        slfb_pkg::CFG_MAX_BRIGHT: cfg_d.max_bright = cfg_data_i[7:0];
        slfb_pkg::CFG_FADE_IVL:   cfg_d.fade_ivl   = cfg_data_i;
        slfb_pkg::CFG_BLINK_IVL:  cfg_d.blink_ivl  = cfg_data_i;
        slfb_pkg::CFG_HOLD_STEPS: cfg_d.hold_steps = cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= slfb_pkg::MODE_OFF;
      cfg_q.max_bright <= slfb_pkg::MaxBrightRst;
      cfg_q.fade_ivl   <= slfb_pkg::FadeIvlRst;
      cfg_q.blink_ivl  <= slfb_pkg::BlinkIvlRst;
      cfg_q.hold_steps <= slfb_pkg::HoldStepsRst;
      state_q.duty     <= 8'd0;
      state_q.dir      <= slfb_pkg::DIR_UP;
      state_q.hold     <= 8'd0;
      elapsed_q        <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign blue_duty_o    = result_q.blue_duty;
  assign white_duty_o   = result_q.white_duty;
  assign stepped_o      = result_q.stepped;
  assign current_mode_o = result_q.current_mode;

endmodule

[sv/slfb_checker.sv]
// Port-level checker for status_led_fade_blink, bound to the top level.
// Depends on assert_macros.svh and slfb_pkg.
`include "assert_macros.svh"

module slfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] blue_duty_o,
  input logic [7:0] white_duty_o,
  input logic       stepped_o,
  input logic [2:0] current_mode_o
);

  logic steady_mode;

  assign steady_mode = (current_mode_o != slfb_pkg::MODE_BLUE_FADE) &&
                       (current_mode_o != slfb_pkg::MODE_WHITE_FADE) &&
                       (current_mode_o != slfb_pkg::MODE_BLUE_BLINK) &&
                       (current_mode_o != slfb_pkg::MODE_WHITE_BLINK);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable({blue_duty_o, white_duty_o, stepped_o, current_mode_o}), "stalled result changed")

  `ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o, "input not ready with empty output")

  `ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o, "accepted request gave no result")

  `ASSERT_IMPL(a_no_step_steady, clk_i, rst_ni, out_valid_o && steady_mode, !stepped_o, "step flagged in steady mode")

  `ASSERT_IMPL(a_one_channel, clk_i, rst_ni, out_valid_o, blue_duty_o == 8'd0 || white_duty_o == 8'd0, "both channels driven")

endmodule

bind status_led_fade_blink slfb_checker u_slfb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .blue_duty_o    (blue_duty_o),
  .white_duty_o   (white_duty_o),
  .stepped_o      (stepped_o),
  .current_mode_o (current_mode_o)
);
